/* sv/sba_pkg.sv */
// Shared constants, types and codes of the sector bitmap allocator.
package sba_pkg;

  // Map geometry
  localparam int unsigned MAP_BITS  = 2048;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned OFS_W     = $clog2(WORD_W);
  localparam int unsigned NUM_WORDS = (MAP_BITS + WORD_W - 1) / WORD_W;
  localparam int unsigned WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned COUNT_W   = $clog2(MAP_BITS + 1);
  localparam int unsigned TAIL_BITS = MAP_BITS - (NUM_WORDS - 1) * WORD_W;

  // Sectors past the end of the map in the last word read as used
  localparam logic [WORD_W-1:0] TAIL_MASK = (TAIL_BITS == WORD_W) ? {WORD_W{1'b1}} :
                                            WORD_W'((64'd1 << TAIL_BITS) - 64'd1);
  localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(NUM_WORDS - 1);

  // Field widths
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned SECTOR_W = 11;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FREE_W   = 12;

  localparam logic [SECTOR_W-1:0] FALLBACK_RESET = 11'd34;

  typedef enum logic [KIND_W-1:0] {
    KIND_PROBE     = 2'd0,
    KIND_ALLOC     = 2'd1,
    KIND_MARK_USED = 2'd2,
    KIND_MARK_FREE = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_NONE  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PASS_GIVEN    = 2'd0,
    PASS_FALLBACK = 2'd1,
    PASS_ZERO     = 2'd2
  } pass_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_EVAL = 2'd2,
    S_EMIT = 2'd3
  } ctrl_state_e;

  typedef struct packed {
    logic load;       // capture request, set up first search pass
    logic read;       // issue map word read
    logic step;       // advance to next map word
    logic next_pass;  // start next allocate search pass
    logic commit;     // update map and count, capture ok result
    logic res_none;   // capture no-free result
    logic res_range;  // capture out-of-range result
    logic emit;       // move result to output register
  } sba_cmd_t;

  typedef struct packed {
    logic range_bad;
    logic skip;
    logic is_mark;
    logic is_alloc;
    logic hit;
    logic last_word;
    logic last_pass;
    logic out_free;
  } sba_stat_t;

endpackage

/* sv/sba_req_if.sv */
// Request channel: kind and sector index with valid/ready.
interface sba_req_if;
  import sba_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [SECTOR_W-1:0] sector_index;

  modport source (output valid, kind, sector_index, input ready);
  modport sink   (input valid, kind, sector_index, output ready);
endinterface

/* sv/sba_rsp_if.sv */
// Result channel: sector, status and free count with valid/ready.
interface sba_rsp_if;
  import sba_pkg::*;

  logic                valid;
  logic                ready;
  logic [SECTOR_W-1:0] sector;
  logic [STATUS_W-1:0] status;
  logic [FREE_W-1:0]   free_count;

  modport source (output valid, sector, status, free_count, input ready);
  modport sink   (input valid, sector, status, free_count, output ready);
endinterface

/* sv/sba_ctrl.sv */
// Request sequencer: steps reads, evaluation and result hand-off.
module sba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  sba_pkg::sba_stat_t stat_i,
  output sba_pkg::sba_cmd_t  cmd_o
);
  import sba_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_READ;
        end
      end
      S_READ: begin
        if (stat_i.range_bad) begin
          cmd_o.res_range = 1'b1;
          state_d         = S_EMIT;
        end else if (stat_i.skip) begin
          // fallback start lies beyond the map: drop this pass
          if (stat_i.last_pass) begin
            cmd_o.res_none = 1'b1;
            state_d        = S_EMIT;
          end else begin
            cmd_o.next_pass = 1'b1;
          end
        end else begin
          cmd_o.read = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat_i.is_mark || stat_i.hit) begin
          cmd_o.commit = 1'b1;
          state_d      = S_EMIT;
        end else if (!stat_i.last_word) begin
          cmd_o.step = 1'b1;
          state_d    = S_READ;
        end else if (stat_i.is_alloc && !stat_i.last_pass) begin
          cmd_o.next_pass = 1'b1;
          state_d         = S_READ;
        end else begin
          cmd_o.res_none = 1'b1;
          state_d        = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* sv/sba_datapath.sv */
// Map memory, search registers, free count and result registers.
module sba_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sba_pkg::sba_cmd_t            cmd_i,
  output sba_pkg::sba_stat_t           stat_o,
  input  logic [sba_pkg::KIND_W-1:0]   req_kind_i,
  input  logic [sba_pkg::SECTOR_W-1:0] req_index_i,
  input  logic                         cfg_we_i,
  input  logic [sba_pkg::SECTOR_W-1:0] cfg_wdata_i,
  input  logic                         rsp_ready_i,
  output logic                         rsp_valid_o,
  output logic [sba_pkg::SECTOR_W-1:0] rsp_sector_o,
  output logic [sba_pkg::STATUS_W-1:0] rsp_status_o,
  output logic [sba_pkg::FREE_W-1:0]   rsp_free_count_o
);
  import sba_pkg::*;

  // Map storage; rows never written read as all free
  logic [WORD_W-1:0]    mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] row_valid_q;
  logic [WORD_W-1:0]    rd_data_q;
  logic                 rd_vld_q;

  kind_e                kind_q;
  logic [SECTOR_W-1:0]  idx_q;
  logic                 range_q;
  pass_e                pass_q;
  logic [WADDR_W-1:0]   word_q;
  logic [OFS_W-1:0]     ofs_q;
  logic                 first_q;
  logic                 skip_q;
  logic [SECTOR_W-1:0]  fallback_q;
  logic [COUNT_W-1:0]   free_q;

  logic [SECTOR_W-1:0]  res_sector_q;
  status_e              res_status_q;
  logic                 out_valid_q;
  logic [SECTOR_W-1:0]  out_sector_q;
  status_e              out_status_q;
  logic [FREE_W-1:0]    out_free_q;

  logic [WORD_W-1:0]    rd_word;
  logic [WORD_W-1:0]    lo_mask;
  logic [WORD_W-1:0]    lim_mask;
  logic [WORD_W-1:0]    free_bits;
  logic                 hit;
  logic [OFS_W-1:0]     hit_pos;
  logic [WADDR_W+OFS_W-1:0] found_sect;
  logic [WORD_W-1:0]    ofs_bit;
  logic [WORD_W-1:0]    hit_bit;
  logic                 is_mark;
  logic                 is_alloc;
  logic                 want_used;
  logic                 flip;
  logic                 wr_en;
  logic [WORD_W-1:0]    wr_data;
  logic [SECTOR_W-1:0]  pass_start;
  pass_e                pass_next;

  assign rd_word   = rd_vld_q ? rd_data_q : '0;
  assign lo_mask   = first_q ? ({WORD_W{1'b1}} << ofs_q) : {WORD_W{1'b1}};
  assign lim_mask  = (word_q == LAST_WORD) ? TAIL_MASK : {WORD_W{1'b1}};
  assign free_bits = ~rd_word & lo_mask & lim_mask;
  assign hit       = |free_bits;

  // lowest free bit of the word
  always_comb begin
    hit_pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        hit_pos = OFS_W'(i);
      end
    end
  end

  assign found_sect = {word_q, hit_pos};
  assign ofs_bit    = WORD_W'(1) << ofs_q;
  assign hit_bit    = WORD_W'(1) << hit_pos;
  assign is_mark    = (kind_q == KIND_MARK_USED) || (kind_q == KIND_MARK_FREE);
  assign is_alloc   = (kind_q == KIND_ALLOC);
  assign want_used  = (kind_q == KIND_MARK_USED);
  assign flip       = want_used != rd_word[ofs_q];

  assign wr_en   = cmd_i.commit && (is_mark ? flip : (is_alloc && hit));
  assign wr_data = is_mark ? (want_used ? (rd_word | ofs_bit) : (rd_word & ~ofs_bit))
                           : (rd_word | hit_bit);

  assign pass_start = (pass_q == PASS_GIVEN) ? fallback_q : '0;
  assign pass_next  = (pass_q == PASS_GIVEN) ? PASS_FALLBACK : PASS_ZERO;

  always_comb begin
    stat_o           = '0;
    stat_o.range_bad = range_q;
    stat_o.skip      = skip_q;
    stat_o.is_mark   = is_mark;
    stat_o.is_alloc  = is_alloc;
    stat_o.hit       = hit;
    stat_o.last_word = (word_q == LAST_WORD);
    stat_o.last_pass = (pass_q == PASS_ZERO);
    stat_o.out_free  = !out_valid_q || rsp_ready_i;
  end

  // map memory: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[word_q] <= wr_data;
    end
    if (cmd_i.read) begin
      rd_data_q <= mem[word_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid_q[word_q] <= 1'b1;
      end
      if (cmd_i.read) begin
        rd_vld_q <= row_valid_q[word_q];
      end
    end
  end

  // search position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= KIND_PROBE;
      idx_q   <= '0;
      range_q <= 1'b0;
      pass_q  <= PASS_GIVEN;
      word_q  <= '0;
      ofs_q   <= '0;
      first_q <= 1'b0;
      skip_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        kind_q  <= kind_e'(req_kind_i);
        idx_q   <= req_index_i;
        range_q <= 32'(req_index_i) >= MAP_BITS;
        pass_q  <= PASS_GIVEN;
        word_q  <= WADDR_W'(req_index_i >> OFS_W);
        ofs_q   <= req_index_i[OFS_W-1:0];
        first_q <= 1'b1;
        skip_q  <= 1'b0;
      end else if (cmd_i.next_pass) begin
        pass_q  <= pass_next;
        word_q  <= WADDR_W'(pass_start >> OFS_W);
        ofs_q   <= pass_start[OFS_W-1:0];
        first_q <= 1'b1;
        skip_q  <= 32'(pass_start) >= MAP_BITS;
      end else if (cmd_i.step) begin
        word_q  <= word_q + WADDR_W'(1);
        first_q <= 1'b0;
      end
    end
  end

  // fallback start register and free count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fallback_q <= FALLBACK_RESET;
      free_q     <= COUNT_W'(MAP_BITS);
    end else begin
      if (cfg_we_i) begin
        fallback_q <= cfg_wdata_i;
      end
      if (wr_en) begin
        if (is_mark && !want_used) begin
          free_q <= free_q + COUNT_W'(1);
        end else begin
          free_q <= free_q - COUNT_W'(1);
        end
      end
    end
  end

  // pending result, then output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_sector_q <= is_mark ? idx_q : SECTOR_W'(found_sect);
      res_status_q <= STAT_OK;
    end else if (cmd_i.res_none) begin
      res_sector_q <= '0;
      res_status_q <= STAT_NONE;
    end else if (cmd_i.res_range) begin
      res_sector_q <= is_mark ? idx_q : '0;
      res_status_q <= STAT_RANGE;
    end
    if (cmd_i.emit) begin
      out_sector_q <= res_sector_q;
      out_status_q <= res_status_q;
      out_free_q   <= FREE_W'(free_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign rsp_valid_o      = out_valid_q;
  assign rsp_sector_o     = out_sector_q;
  assign rsp_status_o     = out_status_q;
  assign rsp_free_count_o = out_free_q;

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= COUNT_W'(MAP_BITS))
    else $error("free count above map size");

  a_alloc_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && is_alloc && hit) |=> (free_q == $past(free_q) - COUNT_W'(1)))
    else $error("allocate did not take one sector from the free count");

  a_row_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> row_valid_q[$past(word_q)])
    else $error("written map row not marked valid");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || rsp_ready_i))
    else $error("result overwrote a word not yet taken");

endmodule

/* sv/sector_bitmap_allocator.sv */
// Flow: a request is accepted while idle; the first map word is then read and evaluated,
// and each further 32-sector word scanned adds another read and evaluation.
// The longest case is an allocate that scans all three passes. Mark requests
// evaluate only the word that holds their sector. One request is in flight at a time;
// the next one is accepted while the previous result waits in the output register.
// Reset clears the map (all free), sets free count to the map size and fallback to 34.
module sector_bitmap_allocator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  sba_req_if.sink                      req,
  sba_rsp_if.source                    rsp,
  input  logic                         cfg_we_i,
  input  logic [sba_pkg::SECTOR_W-1:0] cfg_wdata_i
);
  import sba_pkg::*;

  sba_cmd_t  cmd;
  sba_stat_t stat;

  sba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sba_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .req_kind_i       (req.kind),
    .req_index_i      (req.sector_index),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .rsp_ready_i      (rsp.ready),
    .rsp_valid_o      (rsp.valid),
    .rsp_sector_o     (rsp.sector),
    .rsp_status_o     (rsp.status),
    .rsp_free_count_o (rsp.free_count)
  );

endmodule
